[rtl/lzp_pkg.sv]
// ----------------------------------------------------------------------------
// lzp_pkg
// shared constants for the lidar z-buffer projection block
// ----------------------------------------------------------------------------
`default_nettype none

package lzp_pkg;

  localparam int MAP_ROWS    = 256;
  localparam int MAP_COLS    = 1024;
  localparam int STORE_DEPTH = MAP_ROWS * MAP_COLS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // store entry: depth 22:0, col_sub 42:23, row_sub 62:43
  localparam int DEPTH_W = 23;
  localparam int SUB_W   = 20;
  localparam int ENTRY_W = DEPTH_W + 2 * SUB_W;

  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_OCCLUDED = 3'd1;
  localparam logic [2:0] ST_BEHIND   = 3'd2;
  localparam logic [2:0] ST_OUTSIDE  = 3'd3;
  localparam logic [2:0] ST_ZERO_W   = 3'd4;
  localparam logic [2:0] ST_READ     = 3'd5;

  localparam logic FUNC_PROJECT = 1'b0;
  localparam logic FUNC_READ    = 1'b1;

  localparam logic [2:0] CFG_ROW0_A = 3'd0;
  localparam logic [2:0] CFG_ROW0_B = 3'd1;
  localparam logic [2:0] CFG_ROW1_A = 3'd2;
  localparam logic [2:0] CFG_ROW1_B = 3'd3;
  localparam logic [2:0] CFG_ROW2_A = 3'd4;
  localparam logic [2:0] CFG_ROW2_B = 3'd5;
  localparam logic [2:0] CFG_ROWS   = 3'd6;
  localparam logic [2:0] CFG_COLS   = 3'd7;

endpackage

`default_nettype wire

[rtl/lzp_ram.sv]
// ----------------------------------------------------------------------------
// lzp_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module lzp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/lidar_zbuffer_projection.sv]
// ----------------------------------------------------------------------------
// lidar_zbuffer_projection
// projects lidar points through a 3x4 matrix and keeps the nearest point
// per pixel in a ram-based depth store; also reads store entries back
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  in      | input     | in_valid/in_stall | func, point x/y/z, read row/col
//  out     | output    | out_valid/out_stall| status, pixel, depth, subpixels
//  cfg     | input     | cfg_we            | cfg_index, cfg_wdata
//
//  one word at a time: a point uses the shared 32x24 multiplier, the serial
//  divider for column then row, then ram read, compare and write-back; a
//  read only reads the ram, and a point behind the sensor skips all of it.
//  after reset a clearing pass writes all 262144 store entries, one per
//  cycle, with in_stall high; configuration writes are taken meanwhile.
//  a result waits in the output register while out_stall is high.
`default_nettype none

module lidar_zbuffer_projection (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         in_func,
  input  wire  [23:0] in_point_x,
  input  wire  [23:0] in_point_y,
  input  wire  [23:0] in_point_z,
  input  wire  [7:0]  in_read_row,
  input  wire  [9:0]  in_read_col,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_pixel_row,
  output logic [9:0]  out_pixel_col,
  output logic [22:0] out_depth_out,
  output logic [19:0] out_col_sub,
  output logic [19:0] out_row_sub,
  input  wire         cfg_we,
  input  wire  [2:0]  cfg_index,
  input  wire  [63:0] cfg_wdata
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_MUL      = 4'd2;
  localparam logic [3:0] S_DIV_INIT = 4'd3;
  localparam logic [3:0] S_DIV      = 4'd4;
  localparam logic [3:0] S_CHECK    = 4'd5;
  localparam logic [3:0] S_MEMRD    = 4'd6;
  localparam logic [3:0] S_MEMUSE   = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  localparam int AW = lzp_pkg::ADDR_W;

  logic [3:0]  state_r;
  logic [AW:0] clr_r;

  logic [63:0] proj_r [6];
  logic [8:0]  rows_r;
  logic [10:0] cols_r;

  logic               func_r;
  logic signed [23:0] x_r, y_r, z_r;
  logic        [7:0]  rd_row_r;
  logic        [9:0]  rd_col_r;
  logic               in_map_r;

  logic [3:0]         step_r;
  logic signed [63:0] prod_r;
  logic [1:0]         prod_row_r;
  logic               prod_vld_r;
  logic signed [63:0] u_r, v_r, w_r;

  logic        div_sel_r;
  logic [69:0] rem_r;
  logic [83:0] dsh_r;
  logic [19:0] q_r;
  logic [4:0]  cnt_r;
  logic        sat_r;
  logic        neg_r;
  logic [19:0] csub_r, rsub_r;

  logic [AW-1:0] addr_r;
  logic [7:0]    prow_r;
  logic [9:0]    pcol_r;

  logic [2:0]  res_status_r;
  logic [7:0]  res_row_r;
  logic [9:0]  res_col_r;
  logic [22:0] res_depth_r;
  logic [19:0] res_csub_r, res_rsub_r;
  logic        out_valid_r;

  // ram
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [lzp_pkg::ENTRY_W-1:0] ram_wdata;
  logic [lzp_pkg::ENTRY_W-1:0] ram_rdata;

  lzp_ram #(
    .WIDTH(lzp_pkg::ENTRY_W),
    .DEPTH(lzp_pkg::STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(addr_r),
    .rdata(ram_rdata)
  );

  // multiplier operand select
  logic [2:0]         coef_idx;
  logic [63:0]        coef_reg;
  logic signed [31:0] coef;
  logic signed [23:0] mul_op;
  logic signed [55:0] mul_res;
  logic signed [63:0] prod_nxt;

  always_comb begin
    coef_idx = {step_r[3:2], step_r[1]};
    coef_reg = (coef_idx < 3'd6) ? proj_r[coef_idx] : 64'd0;
    coef     = step_r[0] ? $signed(coef_reg[63:32]) : $signed(coef_reg[31:0]);
    case (step_r[1:0])
      2'd0:    mul_op = x_r;
      2'd1:    mul_op = y_r;
      2'd2:    mul_op = z_r;
      default: mul_op = 24'sd0;
    endcase
    mul_res = coef * mul_op;
    if (step_r[1:0] == 2'd3) begin
      // constant term, scaled by 2^16
      prod_nxt = {{16{coef[31]}}, coef, 16'd0};
    end else begin
      prod_nxt = {{8{mul_res[55]}}, mul_res};
    end
  end

  // divider setup
  logic signed [63:0] num;
  logic [63:0]        nmag, wmag;
  logic [69:0]        dividend;
  logic               div_sat;

  always_comb begin
    num      = div_sel_r ? v_r : u_r;
    nmag     = num[63] ? 64'(-num) : 64'(num);
    wmag     = w_r[63] ? 64'(-w_r) : 64'(w_r);
    dividend = {nmag[63:0], 6'd0};
    div_sat  = {14'd0, dividend} >= {wmag, 20'd0};
  end

  // divider step, one quotient bit a cycle
  logic        rem_ge;
  logic [19:0] q_nxt;
  logic [19:0] mag;
  logic [19:0] sub_val;

  always_comb begin
    rem_ge = {14'd0, rem_r} >= dsh_r;
    q_nxt  = {q_r[18:0], rem_ge};
    mag    = sat_r ? 20'hFFFFF : q_nxt;
    if (!neg_r) begin
      sub_val = (mag > 20'h7FFFF) ? 20'h7FFFF : mag;
    end else begin
      sub_val = (mag > 20'h80000) ? 20'h80000 : 20'(-mag);
    end
  end

  // rounding and bounds
  logic signed [20:0] tc, tr;
  logic [14:0]        col_idx, row_idx;
  logic [15:0]        col_lim, row_lim;
  logic               outside;
  logic [31:0]        pt_addr, rd_addr;

  always_comb begin
    tc      = 21'($signed(csub_r)) + 21'sd32;
    tr      = 21'($signed(rsub_r)) + 21'sd32;
    col_idx = tc[20] ? 15'd0 : tc[20:6];
    row_idx = tr[20] ? 15'd0 : tr[20:6];
    col_lim = (16'(cols_r) < 16'(lzp_pkg::MAP_COLS)) ? 16'(cols_r) : 16'(lzp_pkg::MAP_COLS);
    row_lim = (16'(rows_r) < 16'(lzp_pkg::MAP_ROWS)) ? 16'(rows_r) : 16'(lzp_pkg::MAP_ROWS);
    // truncation toward zero keeps -63..-1 at pixel 0
    outside = (tc <= -21'sd64) || (tr <= -21'sd64) ||
              (16'(col_idx) >= col_lim) || (16'(row_idx) >= row_lim);
    pt_addr = 32'(row_idx) * 32'(lzp_pkg::MAP_COLS) + 32'(col_idx);
    rd_addr = 32'(in_read_row) * 32'(lzp_pkg::MAP_COLS) + 32'(in_read_col);
  end

  // store update
  logic [22:0] stored;
  logic        closer;

  always_comb begin
    stored    = ram_rdata[22:0];
    closer    = (stored == 23'd0) || (stored > x_r[22:0]);
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = {rsub_r, csub_r, x_r[22:0]};
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r[AW-1:0];
      ram_wdata = '0;
    end else if (state_r == S_MEMUSE && func_r == lzp_pkg::FUNC_PROJECT && closer) begin
      ram_we = 1'b1;
    end
  end

  logic in_acc;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        proj_r[i] <= 64'd0;
      end
      rows_r <= 9'd256;
      cols_r <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        lzp_pkg::CFG_ROW0_A: proj_r[0] <= cfg_wdata;
        lzp_pkg::CFG_ROW0_B: proj_r[1] <= cfg_wdata;
        lzp_pkg::CFG_ROW1_A: proj_r[2] <= cfg_wdata;
        lzp_pkg::CFG_ROW1_B: proj_r[3] <= cfg_wdata;
        lzp_pkg::CFG_ROW2_A: proj_r[4] <= cfg_wdata;
        lzp_pkg::CFG_ROW2_B: proj_r[5] <= cfg_wdata;
        lzp_pkg::CFG_ROWS:   rows_r    <= cfg_wdata[8:0];
        lzp_pkg::CFG_COLS:   cols_r    <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      step_r      <= 4'd0;
      prod_vld_r  <= 1'b0;
      div_sel_r   <= 1'b0;
      cnt_r       <= 5'd0;
    end else begin
      // in S_DONE the load below decides the valid flag
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (AW+1)'(lzp_pkg::STORE_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            func_r     <= in_func;
            x_r        <= in_point_x;
            y_r        <= in_point_y;
            z_r        <= in_point_z;
            rd_row_r   <= in_read_row;
            rd_col_r   <= in_read_col;
            step_r     <= 4'd0;
            prod_vld_r <= 1'b0;
            div_sel_r  <= 1'b0;
            u_r        <= 64'sd0;
            v_r        <= 64'sd0;
            w_r        <= 64'sd0;
            if (in_func == lzp_pkg::FUNC_READ) begin
              in_map_r <= (16'(in_read_row) < 16'(lzp_pkg::MAP_ROWS)) &&
                          (16'(in_read_col) < 16'(lzp_pkg::MAP_COLS));
              addr_r   <= AW'(rd_addr);
              state_r  <= S_MEMRD;
            end else if (in_point_x[23]) begin
              res_status_r <= lzp_pkg::ST_BEHIND;
              res_row_r    <= 8'd0;
              res_col_r    <= 10'd0;
              res_depth_r  <= 23'd0;
              res_csub_r   <= 20'd0;
              res_rsub_r   <= 20'd0;
              state_r      <= S_DONE;
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          // multiply at step s, accumulate the product of step s-1
          prod_r     <= prod_nxt;
          prod_row_r <= step_r[3:2];
          prod_vld_r <= (step_r != 4'd12);
          step_r     <= step_r + 4'd1;
          if (prod_vld_r) begin
            case (prod_row_r)
              2'd0:    u_r <= u_r + prod_r;
              2'd1:    v_r <= v_r + prod_r;
              default: w_r <= w_r + prod_r;
            endcase
          end
          if (step_r == 4'd12) begin
            state_r <= S_DIV_INIT;
          end
        end
        S_DIV_INIT: begin
          if (w_r == 64'sd0) begin
            res_status_r <= lzp_pkg::ST_ZERO_W;
            res_row_r    <= 8'd0;
            res_col_r    <= 10'd0;
            res_depth_r  <= x_r[22:0];
            res_csub_r   <= 20'd0;
            res_rsub_r   <= 20'd0;
            state_r      <= S_DONE;
          end else begin
            rem_r   <= dividend;
            dsh_r   <= {1'b0, wmag, 19'd0};
            q_r     <= 20'd0;
            cnt_r   <= 5'd19;
            sat_r   <= div_sat;
            neg_r   <= num[63] ^ w_r[63];
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_ge) begin
            rem_r <= rem_r - dsh_r[69:0];
          end
          dsh_r <= dsh_r >> 1;
          q_r   <= q_nxt;
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) begin
            if (!div_sel_r) begin
              csub_r    <= sub_val;
              div_sel_r <= 1'b1;
              state_r   <= S_DIV_INIT;
            end else begin
              rsub_r  <= sub_val;
              state_r <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (outside) begin
            res_status_r <= lzp_pkg::ST_OUTSIDE;
            res_row_r    <= 8'd0;
            res_col_r    <= 10'd0;
            res_depth_r  <= x_r[22:0];
            res_csub_r   <= csub_r;
            res_rsub_r   <= rsub_r;
            state_r      <= S_DONE;
          end else begin
            addr_r  <= AW'(pt_addr);
            prow_r  <= 8'(row_idx);
            pcol_r  <= 10'(col_idx);
            state_r <= S_MEMRD;
          end
        end
        S_MEMRD: begin
          state_r <= S_MEMUSE;
        end
        S_MEMUSE: begin
          if (func_r == lzp_pkg::FUNC_READ) begin
            res_status_r <= lzp_pkg::ST_READ;
            res_row_r    <= rd_row_r;
            res_col_r    <= rd_col_r;
            res_depth_r  <= in_map_r ? ram_rdata[22:0]  : 23'd0;
            res_csub_r   <= in_map_r ? ram_rdata[42:23] : 20'd0;
            res_rsub_r   <= in_map_r ? ram_rdata[62:43] : 20'd0;
          end else begin
            res_status_r <= closer ? lzp_pkg::ST_STORED : lzp_pkg::ST_OCCLUDED;
            res_row_r    <= prow_r;
            res_col_r    <= pcol_r;
            res_depth_r  <= x_r[22:0];
            res_csub_r   <= csub_r;
            res_rsub_r   <= rsub_r;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r   <= 1'b1;
            out_status    <= res_status_r;
            out_pixel_row <= res_row_r;
            out_pixel_col <= res_col_r;
            out_depth_out <= res_depth_r;
            out_col_sub   <= res_csub_r;
            out_row_sub   <= res_rsub_r;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[rtl/lzp_checker.sv]
// ----------------------------------------------------------------------------
// lzp_checker
// port-level checks on the lidar z-buffer projection block
// ----------------------------------------------------------------------------
`default_nettype none

module lzp_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [2:0]  out_status,
  input wire [7:0]  out_pixel_row,
  input wire [9:0]  out_pixel_col,
  input wire [22:0] out_depth_out,
  input wire [19:0] out_col_sub,
  input wire [19:0] out_row_sub
);

  // held word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_depth_out))
    else $error("result changed while stalled");

  // one word in flight at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // store clearing keeps the input closed after reset
  a_clear: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input open during clearing pass");

  a_behind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == lzp_pkg::ST_BEHIND |->
      out_depth_out == 23'd0 && out_col_sub == 20'd0 && out_row_sub == 20'd0)
    else $error("behind-sensor result carries data");

  a_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == lzp_pkg::ST_OUTSIDE || out_status == lzp_pkg::ST_ZERO_W) |->
      out_pixel_row == 8'd0 && out_pixel_col == 10'd0)
    else $error("dropped point carries a pixel");

endmodule

bind lidar_zbuffer_projection lzp_checker u_lzp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_status   (out_status),
  .out_pixel_row(out_pixel_row),
  .out_pixel_col(out_pixel_col),
  .out_depth_out(out_depth_out),
  .out_col_sub  (out_col_sub),
  .out_row_sub  (out_row_sub)
);

`default_nettype wire

[tb/lidar_zbuffer_projection_tb.sv]
// ----------------------------------------------------------------------------
// lidar_zbuffer_projection_tb
// drives points and store reads through the projection block under random
// idling on both channels, predicts each result word with a local model of
// the projection and depth store, and compares every field
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_zbuffer_projection_tb;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  prow;
    logic [9:0]  pcol;
    logic [22:0] depth;
    logic [19:0] csub;
    logic [19:0] rsub;
  } pix_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_func = lzp_pkg::FUNC_PROJECT;
  logic [23:0] in_point_x = '0;
  logic [23:0] in_point_y = '0;
  logic [23:0] in_point_z = '0;
  logic [7:0]  in_read_row = '0;
  logic [9:0]  in_read_col = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_pixel_row;
  logic [9:0]  out_pixel_col;
  logic [22:0] out_depth_out;
  logic [19:0] out_col_sub;
  logic [19:0] out_row_sub;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  lidar_zbuffer_projection i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the block's state
  logic [63:0] proj_coef [6];
  logic [8:0]  rows_in_use;
  logic [10:0] cols_in_use;
  logic [62:0] depth_store [int];
  pix_result_t expected_words [$];

  int  mismatches = 0;
  bit  quiet_send = 1'b0;   // no gaps on the input side
  bit  quiet_recv = 1'b0;   // no stalls on the output side
  bit  hold_off = 1'b0;
  int  hold_cycles = 0;
  int  idle_cycles = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  function automatic longint coef(int r, bit hi);
    logic [63:0] v;
    v = proj_coef[r];
    return hi ? longint'($signed(v[63:32])) : longint'($signed(v[31:0]));
  endfunction

  function automatic longint to_sub(longint num, longint w);
    longint q;
    q = (num * 64) / w;
    if (q > 524287) q = 524287;
    if (q < -524288) q = -524288;
    return q;
  endfunction

  function automatic pix_result_t project_point(logic f, logic [23:0] px, logic [23:0] py,
                                                logic [23:0] pz, logic [7:0] rr,
                                                logic [9:0] rc);
    pix_result_t res;
    longint x, y, z, u, v, w, cs, rs, pr, pc, lim_r, lim_c;
    logic [62:0] entry;
    int key;
    res = '0;
    if (f == lzp_pkg::FUNC_READ) begin
      res.status = lzp_pkg::ST_READ;
      res.prow = rr;
      res.pcol = rc;
      key = int'(rr) * lzp_pkg::MAP_COLS + int'(rc);
      if (depth_store.exists(key)) begin
        entry = depth_store[key];
        res.depth = entry[22:0];
        res.csub = entry[42:23];
        res.rsub = entry[62:43];
      end
      return res;
    end
    x = longint'($signed(px));
    y = longint'($signed(py));
    z = longint'($signed(pz));
    if (x < 0) begin
      res.status = lzp_pkg::ST_BEHIND;
      return res;
    end
    res.depth = px[22:0];
    u = coef(0, 0) * x + coef(0, 1) * y + coef(1, 0) * z + coef(1, 1) * 65536;
    v = coef(2, 0) * x + coef(2, 1) * y + coef(3, 0) * z + coef(3, 1) * 65536;
    w = coef(4, 0) * x + coef(4, 1) * y + coef(5, 0) * z + coef(5, 1) * 65536;
    if (w == 0) begin
      res.status = lzp_pkg::ST_ZERO_W;
      return res;
    end
    cs = to_sub(u, w);
    rs = to_sub(v, w);
    res.csub = cs[19:0];
    res.rsub = rs[19:0];
    pc = (cs + 32) / 64;
    pr = (rs + 32) / 64;
    lim_r = (rows_in_use < lzp_pkg::MAP_ROWS) ? longint'(rows_in_use) : lzp_pkg::MAP_ROWS;
    lim_c = (cols_in_use < lzp_pkg::MAP_COLS) ? longint'(cols_in_use) : lzp_pkg::MAP_COLS;
    if (pr < 0 || pr >= lim_r || pc < 0 || pc >= lim_c) begin
      res.status = lzp_pkg::ST_OUTSIDE;
      return res;
    end
    res.prow = pr[7:0];
    res.pcol = pc[9:0];
    key = int'(pr) * lzp_pkg::MAP_COLS + int'(pc);
    entry = depth_store.exists(key) ? depth_store[key] : '0;
    if (entry[22:0] == 0 || entry[22:0] > px[22:0]) begin
      depth_store[key] = {res.rsub, res.csub, px[22:0]};
      res.status = lzp_pkg::ST_STORED;
    end else begin
      res.status = lzp_pkg::ST_OCCLUDED;
    end
    return res;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got %0h want %0h", what, got, want);
  endtask

  // result word checker
  always @(posedge clk) begin
    pix_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report("unexpected word", 32'(out_status), 32'd0);
      end else begin
        e = expected_words.pop_front();
        if (out_status !== e.status) report("status", out_status, e.status);
        if (out_pixel_row !== e.prow) report("pixel_row", out_pixel_row, e.prow);
        if (out_pixel_col !== e.pcol) report("pixel_col", out_pixel_col, e.pcol);
        if (out_depth_out !== e.depth) report("depth_out", out_depth_out, e.depth);
        if (out_col_sub !== e.csub) report("col_sub", out_col_sub, e.csub);
        if (out_row_sub !== e.rsub) report("row_sub", out_row_sub, e.rsub);
      end
    end
  end

  // output stall, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_off) begin
      out_stall <= 1'b1;
      hold_cycles++;
      if (hold_cycles >= 300) begin
        hold_off = 1'b0;
        hold_cycles = 0;
      end
    end else if (quiet_recv) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 25);
    end
  end

  // the clearing pass after reset is the longest quiet stretch
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= 1000000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // entered and left at a falling edge
  task automatic send_word(logic f, logic [23:0] px, logic [23:0] py, logic [23:0] pz,
                           logic [7:0] rr, logic [9:0] rc);
    int gap;
    gap = quiet_send ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_func = f;
    in_point_x = px;
    in_point_y = py;
    in_point_z = pz;
    in_read_row = rr;
    in_read_col = rc;
    do @(posedge clk); while (in_stall);
    expected_words.insert(expected_words.size(), project_point(f, px, py, pz, rr, rc));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_point(int x, int y, int z);
    send_word(lzp_pkg::FUNC_PROJECT, x[23:0], y[23:0], z[23:0], 8'($urandom),
              10'($urandom));
  endtask

  task automatic send_read(int r, int c);
    send_word(lzp_pkg::FUNC_READ, 24'($urandom), 24'($urandom), 24'($urandom), r[7:0],
              c[9:0]);
  endtask

  task automatic drain();
    while (expected_words.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    if (idx < lzp_pkg::CFG_ROWS) proj_coef[idx] = val;
    else if (idx == lzp_pkg::CFG_ROWS) rows_in_use = val[8:0];
    else cols_in_use = val[10:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // u = cx*x + f*y, v = cy*x + f*z, w = x + 1.0 ; all in Q16.16
  task automatic set_pinhole(int f, int rows, int cols);
    write_reg(lzp_pkg::CFG_ROW0_A, {32'(f) << 16, 32'(cols) << 15});
    write_reg(lzp_pkg::CFG_ROW0_B, 64'd0);
    write_reg(lzp_pkg::CFG_ROW1_A, {32'd0, 32'(rows) << 15});
    write_reg(lzp_pkg::CFG_ROW1_B, {32'd0, 32'(f) << 16});
    write_reg(lzp_pkg::CFG_ROW2_A, {32'd0, 32'h0001_0000});
    write_reg(lzp_pkg::CFG_ROW2_B, {32'h0001_0000, 32'd0});
    write_reg(lzp_pkg::CFG_ROWS, 64'(rows));
    write_reg(lzp_pkg::CFG_COLS, 64'(cols));
  endtask

  task automatic test_reset_matrix();
    // all coefficients zero, so every point ahead of the sensor has w = 0
    send_point(0, 0, 0);
    send_point(24'h7FFFFF, 24'h7FFFFF, -8388608);
    send_point(65536, -8388608, 24'h7FFFFF);
    send_point(-1, 5, 5);
    send_point(-8388608, 0, 0);
    send_read(0, 0);
    send_read(255, 1023);
  endtask

  task automatic test_directed_pinhole();
    set_pinhole(64, 256, 1024);
    send_point(65536, 0, 0);                // empty pixel (64, 256), stored
    send_point(32768, 0, 0);                // nearer, lands on another pixel, stored
    send_point(65536, 0, 0);                // same depth as the first, occluded
    send_point(32768, 0, 0);                // equal depth, occluded
    send_point(0, 0, 0);                    // zero depth stored
    send_point(0, 0, 0);                    // entry still empty
    send_point(24'h7FFFFF, 0, 0);           // far point on another pixel, stored
    send_point(1, 24'h7FFFFF, -8388608);    // subpixels near their limits, outside
    send_point(65536, 1 << 20, 0);          // further right at (64, 768), stored
    send_point(65536, 0, -(1 << 20));       // above the image
    send_point(-1, 0, 0);
    send_read(128, 512);
    send_read(0, 1023);
    drain();
    write_reg(lzp_pkg::CFG_ROWS, 64'd0);    // nothing is inside
    send_point(65536, 0, 0);
    drain();
    write_reg(lzp_pkg::CFG_ROWS, 64'd511);
    write_reg(lzp_pkg::CFG_COLS, 64'd0);
    send_point(65536, 0, 0);
    drain();
    write_reg(lzp_pkg::CFG_COLS, 64'd2047);
    send_point(65536, 100, 200);
    send_read(128, 512);
    drain();
  endtask

  task automatic test_random_points(int f, int rows, int cols, int n);
    int x;
    set_pinhole(f, rows, cols);
    repeat (n) begin
      if ($urandom_range(99) < 25) begin
        send_read($urandom_range(rows - 1), $urandom_range(cols - 1));
      end else begin
        x = (($urandom_range(99) < 50) ? $urandom_range(8) : $urandom_range(2000)) << 12;
        if ($urandom_range(99) < 5) x = -$urandom_range(8388608, 1);
        send_point(x, $signed($urandom_range(2 * x + 2)) - x - 1,
                   $signed($urandom_range(2 * x + 2)) - x - 1);
      end
    end
    drain();
  endtask

  task automatic test_noise(int n);
    for (int i = 0; i < 6; i++) begin
      case ($urandom_range(3))
        0: write_reg(3'(i), 64'h8000_0000_8000_0000);
        1: write_reg(3'(i), 64'h7FFF_FFFF_7FFF_FFFF);
        default: write_reg(3'(i), {$urandom, $urandom});
      endcase
    end
    write_reg(lzp_pkg::CFG_ROWS, 64'($urandom_range(511)));
    write_reg(lzp_pkg::CFG_COLS, 64'($urandom_range(2047)));
    repeat (n) begin
      send_word(1'($urandom), 24'($urandom), 24'($urandom), 24'($urandom), 8'($urandom),
                10'($urandom));
    end
    drain();
  endtask

  task automatic test_pressure();
    set_pinhole(32, 16, 32);
    hold_off = 1'b1;
    quiet_send = 1'b1;
    repeat (30) send_point($urandom_range(1 << 18), $urandom_range(1 << 14), 0);
    quiet_send = 1'b0;
    drain();
    // no idling at all for a stretch
    quiet_send = 1'b1;
    quiet_recv = 1'b1;
    repeat (40) send_point($urandom_range(1 << 18), $urandom_range(1 << 14),
                           $urandom_range(1 << 14));
    repeat (10) send_read($urandom_range(15), $urandom_range(31));
    quiet_send = 1'b0;
    quiet_recv = 1'b0;
    drain();
  endtask

  initial begin
    foreach (proj_coef[i]) proj_coef[i] = '0;
    rows_in_use = 9'd256;
    cols_in_use = 11'd1024;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    test_reset_matrix();
    drain();
    test_directed_pinhole();
    test_random_points(400, 256, 1024, 300);
    test_random_points(4, 8, 16, 300);
    test_random_points(1, 1, 1, 150);
    test_random_points(20, 16, 4, 300);
    test_noise(200);
    test_noise(150);
    test_pressure();
    drain();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
